/* rtl/msq_pkg.sv */
package msq_pkg;
  localparam int unsigned Servers    = 16;
  localparam int unsigned QueueDepth = 1024;
  localparam int unsigned TimeBits   = 48;
  localparam int unsigned SrvW       = $clog2(Servers);
  localparam int unsigned QAddrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 5;
  localparam logic [TimeBits-1:0] TMax = '1;

  localparam logic [CfgIdxW-1:0] CfgDelayMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgServers   = 1'b1;

  typedef enum logic [1:0] {
    OutServed   = 2'd0,
    OutBlocked  = 2'd1,
    OutQueued   = 2'd2,
    OutOverflow = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDecide,
    StAreaMul,
    StDeqRead,
    StDeqApply,
    StArrive,
    StFinish
  } state_e;

  typedef struct packed {
    logic [31:0] interarrival;
    logic [31:0] service_time;
  } req_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [3:0]  server_index;
    logic [47:0] arrival_time;
    logic [10:0] queue_length;
    logic [31:0] arrival_count;
    logic [31:0] served_count;
    logic [31:0] blocked_count;
    logic [31:0] waited_count;
    logic [63:0] total_wait;
    logic [63:0] busy_area;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch request, compute arrival time
    logic scan_clr;   // restart departure scan
    logic scan_step;  // examine one server
    logic area_mul;   // register busy x elapsed product
    logic area_add;   // fold product into area, advance event time
    logic retire;     // retire found departure (no queued call to start)
    logic deq_apply;  // restart server with queue head
    logic arrive;     // place the arrival
    logic finish;     // emit the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic dep_due;    // earliest departure lies before arrival
    logic dequeue;    // due departure serves the queue head
  } sts_t;

  function automatic logic [TimeBits-1:0] tadd(logic [TimeBits-1:0] a, logic [31:0] b);
    logic [TimeBits:0] s;
    s = {1'b0, a} + {{(TimeBits - 31){1'b0}}, b};
    return s[TimeBits] ? TMax : s[TimeBits-1:0];
  endfunction

  function automatic logic [63:0] add64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] inc32(logic [31:0] c);
    return (&c) ? c : c + 32'd1;
  endfunction
endpackage

/* rtl/msq_ram.sv */
module msq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/msq_ctrl.sv */
module msq_ctrl import msq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != StIdle);
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = StDecide;
      end
      StDecide: begin
        state_d = StAreaMul;
      end
      StAreaMul: begin
        cmd_o.area_mul = 1'b1;
        state_d        = StDeqRead;
      end
      StDeqRead: begin
        // apply area for this event (departure or the arrival itself)
        cmd_o.area_add = 1'b1;
        if (!sts_i.dep_due) begin
          state_d = StArrive;
        end else if (sts_i.dequeue) begin
          state_d = StDeqApply;
        end else begin
          cmd_o.retire   = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = StScan;
        end
      end
      StDeqApply: begin
        cmd_o.deq_apply = 1'b1;
        cmd_o.scan_clr  = 1'b1;
        state_d         = StScan;
      end
      StArrive: begin
        cmd_o.arrive = 1'b1;
        state_d      = StFinish;
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

/* rtl/msq_dp.sv */
module msq_dp import msq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  req_t                req_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output sts_t                sts_o,
  output logic                done_o,
  output rsp_t                rsp_o
);
  logic                delay_q;
  logic [4:0]          nsrv_q;
  logic [TimeBits-1:0] arr_q, last_q;
  logic [31:0]         svc_q;
  logic [Servers-1:0]  sbusy_q;
  logic [TimeBits-1:0] dep_q [Servers];
  logic [SrvW:0]       bsrv_q;
  logic [QAddrW-1:0]   head_q;
  logic [QCntW-1:0]    qcnt_q;
  logic [31:0]         arrc_q, srvc_q, blkc_q, wtc_q;
  logic [63:0]         wsum_q, area_q;
  logic [63:0]         prod_q;
  // departure scan
  logic [SrvW:0]       sidx_q;
  logic                bfound_q;
  logic [SrvW-1:0]     best_q;
  logic [TimeBits-1:0] bt_q;
  logic                done_q;
  rsp_t                rsp_q;

  logic [TimeBits-1:0] evt_t;
  logic [SrvW-1:0]     sptr;
  logic                due;
  logic [QAddrW-1:0]   tail;
  logic [QAddrW:0]     tail_sum;
  logic [TimeBits+31:0] q_rd;
  logic                q_we;
  logic [4:0]          nact;
  logic                free_ok;
  logic [SrvW-1:0]     free_idx;

  assign sptr = sidx_q[SrvW-1:0];
  assign due  = bfound_q && (bt_q < arr_q);
  assign evt_t = due ? bt_q : arr_q;
  assign sts_o.scan_done = (sidx_q == (SrvW+1)'(Servers));
  assign sts_o.dep_due   = due;
  assign sts_o.dequeue   = delay_q && (qcnt_q != '0);

  assign tail_sum = {1'b0, head_q} + qcnt_q[QAddrW:0];
  assign tail = (tail_sum >= (QAddrW+1)'(QueueDepth)) ?
                QAddrW'(tail_sum - (QAddrW+1)'(QueueDepth)) : tail_sum[QAddrW-1:0];
  assign q_we = cmd_i.arrive && !free_ok && delay_q &&
                (qcnt_q < QCntW'(QueueDepth));

  msq_ram #(.Width(TimeBits + 32), .Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail),
    .wdata_i ({arr_q, svc_q}),
    .raddr_i (head_q),
    .rdata_o (q_rd)
  );

  always_comb begin
    nact = nsrv_q;
    if (nact == 5'd0) nact = 5'd1;
    if (nact > 5'(Servers)) nact = 5'(Servers);
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = Servers - 1; i >= 0; i--) begin
      if (!sbusy_q[i] && (5'(i) < nact)) begin
        free_ok  = 1'b1;
        free_idx = SrvW'(i);
      end
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= 1'b0;
      nsrv_q  <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDelayMode: delay_q <= cfg_data_i[0];
        CfgServers:   nsrv_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      svc_q <= req_i.service_time;
    end
    if (cmd_i.area_mul) begin
      prod_q <= 64'(bsrv_q) * 64'(evt_t - last_q);
    end
    if (cmd_i.deq_apply) dep_q[best_q] <= tadd(bt_q, q_rd[31:0]);
    if (cmd_i.arrive && free_ok) dep_q[free_idx] <= tadd(arr_q, svc_q);
    if (cmd_i.scan_clr) begin
      bt_q <= '0;
    end else if (cmd_i.scan_step && !sts_o.scan_done && sbusy_q[sptr] &&
                 (!bfound_q || dep_q[sptr] < bt_q)) begin
      bt_q   <= dep_q[sptr];
      best_q <= sptr;
    end
    if (cmd_i.finish) begin
      rsp_q.arrival_time  <= arr_q;
      rsp_q.queue_length  <= qcnt_q;
      rsp_q.arrival_count <= arrc_q;
      rsp_q.served_count  <= srvc_q;
      rsp_q.blocked_count <= blkc_q;
      rsp_q.waited_count  <= wtc_q;
      rsp_q.total_wait    <= wsum_q;
      rsp_q.busy_area     <= area_q;
    end
    if (cmd_i.arrive) begin
      rsp_q.server_index <= free_ok ? 4'(free_idx) : 4'd0;
      if (free_ok)               rsp_q.outcome <= OutServed;
      else if (!delay_q)         rsp_q.outcome <= OutBlocked;
      else if (q_we)             rsp_q.outcome <= OutQueued;
      else                       rsp_q.outcome <= OutOverflow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arr_q    <= '0;
      last_q   <= '0;
      sbusy_q  <= '0;
      bsrv_q   <= '0;
      head_q   <= '0;
      qcnt_q   <= '0;
      arrc_q   <= '0;
      srvc_q   <= '0;
      blkc_q   <= '0;
      wtc_q    <= '0;
      wsum_q   <= '0;
      area_q   <= '0;
      sidx_q   <= '0;
      bfound_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.load) arr_q <= tadd(arr_q, req_i.interarrival);
      if (cmd_i.scan_clr) begin
        sidx_q   <= '0;
        bfound_q <= 1'b0;
      end else if (cmd_i.scan_step && !sts_o.scan_done) begin
        sidx_q <= sidx_q + 1'b1;
        if (sbusy_q[sptr] && (!bfound_q || dep_q[sptr] < bt_q)) bfound_q <= 1'b1;
      end
      if (cmd_i.area_add) begin
        if (!delay_q && evt_t > last_q) area_q <= add64(area_q, prod_q);
        last_q <= evt_t;
      end
      if (cmd_i.retire) begin
        sbusy_q[best_q] <= 1'b0;
        if (bsrv_q != '0) bsrv_q <= bsrv_q - 1'b1;
      end
      if (cmd_i.deq_apply) begin
        head_q <= (32'(head_q) + 1 >= QueueDepth) ? '0 : head_q + 1'b1;
        qcnt_q <= qcnt_q - 1'b1;
        if (bt_q > q_rd[TimeBits+31:32])
          wsum_q <= add64(wsum_q, 64'(bt_q - q_rd[TimeBits+31:32]));
        srvc_q <= inc32(srvc_q);
      end
      if (cmd_i.arrive) begin
        arrc_q <= inc32(arrc_q);
        if (free_ok) begin
          sbusy_q[free_idx] <= 1'b1;
          bsrv_q <= bsrv_q + 1'b1;
          srvc_q <= inc32(srvc_q);
        end else if (!delay_q) begin
          blkc_q <= inc32(blkc_q);
        end else if (q_we) begin
          qcnt_q <= qcnt_q + 1'b1;
          wtc_q  <= inc32(wtc_q);
        end
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;
endmodule

/* rtl/multi_server_queue_event_engine.sv */
// Multi-server queue event engine: one discrete-event step per request.
// Request channel: drive req_i and pulse start_i while busy_o is low; the
// request is taken at that edge. req_i carries the interarrival time and
// the service time of one call, in ticks with 16 fractional bits.
// Result channel: rsp_valid_o is high for exactly one cycle with rsp_o
// holding outcome, server taken, arrival time, queue length and the
// saturating statistics. The receiver cannot stall; take it or lose it.
// Configuration: cfg_we_i, cfg_idx_i (0 delay mode, 1 servers in use) and
// cfg_data_i, for the user to write only while busy_o is low (unchecked).
// Sequence: a departure scan walks the 16 departure registers one per
// cycle; each departure retired before the arrival passes StDecide,
// StAreaMul and StDeqRead (and StDeqApply when it starts a queued call),
// then a new scan; the arrival passes a final scan, StDecide, StAreaMul,
// StDeqRead, StArrive and StFinish, and the strobe follows in the next
// cycle. The serial scan sets pace.
// busy_o stays high through the result strobe.
// Reset: clock, counters, sums, queue pointers and server flags clear at
// once; the queue memory holds no reset and is read only where written.
module multi_server_queue_event_engine import msq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  req_t                req_i,
  output logic                busy_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                rsp_valid_o,
  output rsp_t                rsp_o
);
  cmd_t cmd;
  sts_t sts;
  logic ctrl_busy;

  // drop a start that arrives during the result cycle
  msq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i && !rsp_valid_o),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (ctrl_busy)
  );

  msq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sts_o      (sts),
    .done_o     (rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  // hold busy through the result cycle so a new request follows the strobe
  assign busy_o = ctrl_busy | rsp_valid_o;

`ifndef NO_ASSERTIONS
  a_rsp_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> rsp_valid_o) else $error("result strobe missing");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.retire, cmd.deq_apply, cmd.arrive, cmd.finish}))
    else $error("conflicting datapath commands");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !cmd.load) else $error("request taken during result");
`endif
endmodule
